FILE: sv/shbi_pkg.sv
// ----------------------------------------------------------------------------
// String hash bucket index: shared package
// Widths, the hash seed and the status record shared by the top level and
// the remainder unit.
// ----------------------------------------------------------------------------
package shbi_pkg;

	// Field and datapath widths.
	localparam int unsigned CP_W   = 21;
	localparam int unsigned HASH_W = 64;
	localparam int unsigned SIZE_W = 32;

	// Starting value of the running hash for every key.
	localparam logic [HASH_W-1:0] HASH_SEED = 64'd75025;

	// Table size after reset.
	localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 32'd7;

	// Status of the remainder unit as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} shbi_mod_stat_t;

endpackage

FILE: sv/string_hash_bucket_index.sv
// ----------------------------------------------------------------------------
// String hash bucket index: top level
// Hashes a key one code point per transfer and returns its bucket index.
// ----------------------------------------------------------------------------
// A key streams in one code point per transfer, with last set on its final
// code point. For each nonzero code point that is not last, the running
// 64-bit hash (seed 75025) becomes hash*33 + code point + 1, and the block
// takes the next transfer in the following cycle. A zero code point ends
// hashing; later code points of that key are ignored. The transfer flagged
// last hashes its code point and then starts the modulo by table_size, which
// runs in a one-bit-per-cycle restoring divider: key_stall stays high after
// that transfer through the 64 divide steps and the hand-off, longer
// only if the previous result is still held in the output register. A table
// size of zero gives index zero. table_size is written through
// table_size_we/table_size_wdata and must only change while no key is in
// flight.
module string_hash_bucket_index
	import shbi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Configuration
	input  logic              table_size_we,
	input  logic [SIZE_W-1:0] table_size_wdata,
	// Key channel
	input  logic              key_valid,
	output logic              key_stall,
	input  logic [CP_W-1:0]   code_point,
	input  logic              last,
	// Bucket channel
	output logic              bucket_valid,
	input  logic              bucket_stall,
	output logic [SIZE_W-1:0] bucket_index
);

	logic [SIZE_W-1:0] table_size_q;
	logic [HASH_W-1:0] hash_q;
	logic              term_q;
	logic              bucket_valid_q;
	logic [SIZE_W-1:0] bucket_index_q;

	logic              key_xfer;
	logic              hash_en;
	logic [HASH_W-1:0] hash_upd;
	logic [HASH_W-1:0] hash_next;
	logic              mod_start;
	logic              mod_take;
	shbi_mod_stat_t    mod_stat;
	logic [SIZE_W-1:0] mod_rem;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RST;
		end else if (table_size_we) begin
			table_size_q <= table_size_wdata;
		end
	end

	// Handshake on the key side: closed while a modulo is outstanding.
	assign key_stall = mod_stat.busy;
	assign key_xfer  = key_valid && !key_stall;

	// Hash update: hash*33 + code point + 1, wrapping at 64 bits.
	assign hash_en   = !term_q && (code_point != '0);
	assign hash_upd  = (hash_q << 5) + hash_q + HASH_W'(code_point) + HASH_W'(1);
	assign hash_next = hash_en ? hash_upd : hash_q;

	assign mod_start = key_xfer && last;

	// Running hash and terminator flag; the key state restarts after last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
			term_q <= 1'b0;
		end else if (key_xfer) begin
			if (last) begin
				hash_q <= HASH_SEED;
				term_q <= 1'b0;
			end else begin
				hash_q <= hash_next;
				if (code_point == '0) begin
					term_q <= 1'b1;
				end
			end
		end
	end

	// Remainder unit shared by every key.
	shbi_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (hash_next),
		.divisor   (table_size_q),
		.take      (mod_take),
		.stat      (mod_stat),
		.remainder (mod_rem)
	);

	// The result moves to the output register once that register is free.
	assign mod_take = mod_stat.done && (!bucket_valid_q || !bucket_stall);

	// Output register of the bucket channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_valid_q <= 1'b0;
		end else if (mod_take) begin
			bucket_valid_q <= 1'b1;
		end else if (!bucket_stall) begin
			bucket_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mod_take) begin
			bucket_index_q <= mod_rem;
		end
	end

	assign bucket_valid = bucket_valid_q;
	assign bucket_index = bucket_index_q;

endmodule

FILE: sv/shbi_mod.sv
// ----------------------------------------------------------------------------
// String hash bucket index: remainder unit
// Restoring binary division that yields the 64-bit hash modulo the 32-bit
// table size, one dividend bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
module shbi_mod
	import shbi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] dividend,
	input  logic [SIZE_W-1:0] divisor,
	input  logic              take,
	output shbi_mod_stat_t    stat,
	output logic [SIZE_W-1:0] remainder
);

	localparam int unsigned CNT_W = $clog2(HASH_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [HASH_W-1:0]  dvd_q;
	logic [SIZE_W-1:0]  dvs_q;
	logic               dvs_zero_q;
	logic [SIZE_W-1:0]  rem_q;

	logic [SIZE_W:0]    trial;
	logic [SIZE_W+1:0]  diff;

	// One restoring step: shift in the next dividend bit and try the subtract.
	assign trial = {rem_q, dvd_q[HASH_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			dvd_q      <= '0;
			dvs_q      <= '0;
			dvs_zero_q <= 1'b0;
			rem_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q    <= ST_RUN;
						cnt_q      <= CNT_W'(HASH_W - 1);
						dvd_q      <= dividend;
						dvs_q      <= divisor;
						dvs_zero_q <= (divisor == '0);
						rem_q      <= '0;
					end
				end
				ST_RUN: begin
					dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
					if (diff[SIZE_W+1]) begin
						rem_q <= trial[SIZE_W-1:0];
					end else begin
						rem_q <= diff[SIZE_W-1:0];
					end
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);

	// A table of zero buckets maps every key to index zero.
	assign remainder = dvs_zero_q ? '0 : rem_q;

endmodule
